// ===== rtl/core/stri_pkg.sv =====
// Shared constants, widths, register codes and word types for the stereo
// triangulation block. No dependencies; every other file imports this one.
`timescale 1ns / 1ps
`default_nettype none

package stri_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int COORD_BITS = 16;

    // Centre in half pixels: 2*corner + size.
    localparam int CTR_W  = PIXEL_BITS + 2;
    localparam int DH_W   = CTR_W + 1;
    localparam int PP_W   = 16;
    localparam int UV_W   = ((CTR_W + 3 > PP_W) ? CTR_W + 3 : PP_W) + 1;

    localparam int GAIN_W    = 24;
    localparam int SKEW_W    = 18;
    localparam int ZG_W      = 32;
    localparam int ROW_W     = 64;
    localparam int ROT_W     = 16;
    localparam int SKEW_FRAC = 16;

    localparam int XT_W    = UV_W + SKEW_W + 1;
    localparam int XT_LO_W = (XT_W + 1) / 2;
    localparam int XT_HI_W = XT_W - XT_LO_W;
    localparam int PX_LO_W = GAIN_W + XT_LO_W;
    localparam int PX_HI_W = GAIN_W + XT_HI_W;
    localparam int PX_W    = GAIN_W + XT_W;
    localparam int YP_W    = GAIN_W + UV_W;

    localparam int X_SHIFT = 11;
    localparam int Y_SHIFT = 5;
    localparam int Z_SHIFT = 9;
    localparam int NUM_W   = PX_W - X_SHIFT;

    localparam int DIV_STEPS  = 5;
    localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

    localparam int CAM_LIMIT_LOG = 40;
    localparam int CAM_W         = CAM_LIMIT_LOG + 2;
    localparam int CAM_LO_W      = CAM_W / 2;
    localparam int CAM_HI_W      = CAM_W - CAM_LO_W;
    localparam logic [NUM_W-1:0] CAM_MAX = NUM_W'(1) << CAM_LIMIT_LOG;

    localparam int OUT_FRAC = 30;
    localparam int ACC_W    = ROT_W + CAM_W + 2;
    localparam longint ROUND_ADD = (longint'(1) <<< OUT_FRAC) - 1;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CNT_W      = FIFO_AW + 1;

    localparam int APB_AW = 6;
    localparam int APB_DW = 64;
    localparam int IDX_LSB = 3;

    typedef enum logic [2:0] {
        REG_BASELINE,
        REG_SKEW,
        REG_Y_GAIN,
        REG_Z_GAIN,
        REG_PRINCIPAL,
        REG_ROW_X,
        REG_ROW_Y,
        REG_ROW_Z
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] baseline_gain;
        logic [SKEW_W-1:0] skew_ratio;
        logic [GAIN_W-1:0] y_gain;
        logic [ZG_W-1:0]   z_gain;
        logic [2*PP_W-1:0] principal_point;
        logic [ROW_W-1:0]  row_x;
        logic [ROW_W-1:0]  row_y;
        logic [ROW_W-1:0]  row_z;
    } cfg_t;

    // Divide job handed from front to back.
    typedef struct packed {
        logic [NUM_W-1:0] nx;
        logic [NUM_W-1:0] ny;
        logic [NUM_W-1:0] nz;
        logic [CTR_W-1:0] den;
        logic             neg_x;
        logic             neg_y;
        logic             neg_z;
        logic             zero;
    } item_t;

    typedef struct packed {
        logic zero;
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } sb_t;

endpackage

`default_nettype wire

// ===== rtl/core/stri_if.sv =====
// Valid/ready channel interfaces for detection words in and base words out.
// Depends on stri_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface stri_in_if;
    import stri_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] left_box_x;
    logic [PIXEL_BITS-1:0] left_box_y;
    logic [PIXEL_BITS-1:0] left_box_w;
    logic [PIXEL_BITS-1:0] left_box_h;
    logic [PIXEL_BITS-1:0] right_box_x;
    logic [PIXEL_BITS-1:0] right_box_y;
    logic [PIXEL_BITS-1:0] right_box_w;
    logic [PIXEL_BITS-1:0] right_box_h;

    modport source (
        output valid, left_box_x, left_box_y, left_box_w, left_box_h,
               right_box_x, right_box_y, right_box_w, right_box_h,
        input  ready
    );
    modport sink (
        input  valid, left_box_x, left_box_y, left_box_w, left_box_h,
               right_box_x, right_box_y, right_box_w, right_box_h,
        output ready
    );
endinterface

interface stri_out_if;
    import stri_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic signed [COORD_BITS-1:0] base_z;
    logic                         zero_disparity;

    modport source (
        output valid, base_x, base_y, base_z, zero_disparity,
        input  ready
    );
    modport sink (
        input  valid, base_x, base_y, base_z, zero_disparity,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/stereo_triangulate_to_base.sv =====
// Stereo triangulation of one matched left/right detection into robot base
// millimetres. A detection word is accepted on in_ch when valid and ready are
// high; one result word leaves on out_ch per detection, in order. The block
// sustains one word per clock unless out_ch stalls: the front end (three
// stages: centres and disparity, skew product, gain products) feeds a
// four-entry queue, and the back end runs three 50-bit dividers pipelined
// five quotient bits per stage (ten stages), then camera saturation, the
// transform products, the row sums and the output register. Registers sit on
// the APB port at byte address 8*index and should only be written while no
// word is in flight. Depends on stri_pkg, stri_if and all stri_* modules.
`timescale 1ns / 1ps
`default_nettype none

module stereo_triangulate_to_base (
    input  logic                         clk,
    input  logic                         rst_n,
    stri_in_if.sink                      in_ch,
    stri_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stri_pkg::APB_AW-1:0]  paddr,
    input  logic [stri_pkg::APB_DW-1:0]  pwdata,
    output logic [stri_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import stri_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;
    logic     push, fifo_full, pop, fifo_valid;
    item_t    push_item, pop_item;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:IDX_LSB]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (wr_en)
        begin
            case (idx)
                REG_BASELINE:  cfg_reg.baseline_gain   <= pwdata[GAIN_W-1:0];
                REG_SKEW:      cfg_reg.skew_ratio      <= pwdata[SKEW_W-1:0];
                REG_Y_GAIN:    cfg_reg.y_gain          <= pwdata[GAIN_W-1:0];
                REG_Z_GAIN:    cfg_reg.z_gain          <= pwdata[ZG_W-1:0];
                REG_PRINCIPAL: cfg_reg.principal_point <= pwdata[2*PP_W-1:0];
                REG_ROW_X:     cfg_reg.row_x           <= pwdata[ROW_W-1:0];
                REG_ROW_Y:     cfg_reg.row_y           <= pwdata[ROW_W-1:0];
                REG_ROW_Z:     cfg_reg.row_z           <= pwdata[ROW_W-1:0];
                default:       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_BASELINE:  prdata = APB_DW'(cfg_reg.baseline_gain);
            REG_SKEW:      prdata = APB_DW'(cfg_reg.skew_ratio);
            REG_Y_GAIN:    prdata = APB_DW'(cfg_reg.y_gain);
            REG_Z_GAIN:    prdata = APB_DW'(cfg_reg.z_gain);
            REG_PRINCIPAL: prdata = APB_DW'(cfg_reg.principal_point);
            REG_ROW_X:     prdata = APB_DW'(cfg_reg.row_x);
            REG_ROW_Y:     prdata = APB_DW'(cfg_reg.row_y);
            REG_ROW_Z:     prdata = APB_DW'(cfg_reg.row_z);
            default:       prdata = '0;
        endcase
    end

    stri_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_ch     (in_ch),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    stri_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (fifo_valid)
    );

    stri_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fifo_valid (fifo_valid),
        .fifo_item  (pop_item),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// ===== rtl/core/stri_front.sv =====
// Front end: accepts detection words, forms centres, disparity and the three
// divide numerators, and pushes one divide job per word. Uses stri_pkg, stri_if.
`timescale 1ns / 1ps
`default_nettype none

module stri_front (
    input  logic           clk,
    input  logic           rst_n,
    input  stri_pkg::cfg_t cfg,
    stri_in_if.sink        in_ch,
    input  logic           fifo_full,
    output logic           push,
    output stri_pkg::item_t push_item
);
    import stri_pkg::*;

    logic adv;
    logic s1_v_reg, s2_v_reg, s3_v_reg;

    logic [CTR_W-1:0]        lcx, lcy, rcx;
    logic signed [DH_W-1:0]  dh_next;
    logic signed [UV_W-1:0]  u_next, v_next;

    logic signed [DH_W-1:0]  s1_dh_reg;
    logic signed [UV_W-1:0]  s1_u_reg, s1_vc_reg;

    logic signed [SKEW_W+UV_W-1:0] sv_prod;
    logic signed [XT_W-1:0]        xt_next;
    logic [UV_W-1:0]               vabs;
    logic [YP_W-1:0]               yp_next;

    logic signed [DH_W-1:0]  s2_dh_reg;
    logic signed [XT_W-1:0]  s2_xt_reg;
    logic [YP_W-1:0]         s2_yp_reg;
    logic                    s2_vneg_reg;

    logic [XT_W-1:0]         xtm;
    logic [PX_LO_W-1:0]      px_lo_next;
    logic [PX_HI_W-1:0]      px_hi_next;

    logic signed [DH_W-1:0]  s3_dh_reg;
    logic [PX_LO_W-1:0]      s3_px_lo_reg;
    logic [PX_HI_W-1:0]      s3_px_hi_reg;
    logic [YP_W-1:0]         s3_yp_reg;
    logic                    s3_xneg_reg;
    logic                    s3_vneg_reg;

    logic [PX_W-1:0]         px_sum;
    logic [CTR_W-1:0]        dabs;
    logic                    dzero;

    // Hold the whole front while the queue is full and a job waits.
    assign adv         = !s3_v_reg || !fifo_full;
    assign in_ch.ready = adv;
    assign push        = s3_v_reg && !fifo_full;

    always_comb
    begin
        lcx = CTR_W'({in_ch.left_box_x, 1'b0}) + CTR_W'(in_ch.left_box_w);
        lcy = CTR_W'({in_ch.left_box_y, 1'b0}) + CTR_W'(in_ch.left_box_h);
        rcx = CTR_W'({in_ch.right_box_x, 1'b0}) + CTR_W'(in_ch.right_box_w);
        dh_next = $signed({1'b0, lcx}) - $signed({1'b0, rcx});
        u_next  = $signed(UV_W'({lcx, 3'b000}))
                - $signed(UV_W'(cfg.principal_point[2*PP_W-1:PP_W]));
        v_next  = $signed(UV_W'({lcy, 3'b000}))
                - $signed(UV_W'(cfg.principal_point[PP_W-1:0]));
    end

    always_comb
    begin
        sv_prod = $signed(cfg.skew_ratio) * s1_vc_reg;
        xt_next = (XT_W'(s1_u_reg) <<< SKEW_FRAC) - XT_W'(sv_prod);
        vabs    = UV_W'(s1_vc_reg[UV_W-1] ? -s1_vc_reg : s1_vc_reg);
        yp_next = cfg.y_gain * vabs;
    end

    always_comb
    begin
        xtm        = s2_xt_reg[XT_W-1] ? XT_W'(-s2_xt_reg) : XT_W'(s2_xt_reg);
        px_lo_next = cfg.baseline_gain * xtm[XT_LO_W-1:0];
        px_hi_next = cfg.baseline_gain * xtm[XT_W-1:XT_LO_W];
    end

    always_comb
    begin
        px_sum = PX_W'(s3_px_lo_reg) + (PX_W'(s3_px_hi_reg) << XT_LO_W);
        dabs   = CTR_W'(s3_dh_reg[DH_W-1] ? -s3_dh_reg : s3_dh_reg);
        dzero  = (s3_dh_reg == '0);
        push_item.nx    = px_sum[PX_W-1:X_SHIFT];
        push_item.ny    = NUM_W'(s3_yp_reg) << Y_SHIFT;
        push_item.nz    = NUM_W'(cfg.z_gain) << Z_SHIFT;
        // Keep the divisor nonzero; the result is forced to zero anyway.
        push_item.den   = dzero ? CTR_W'(1) : dabs;
        push_item.neg_x = s3_xneg_reg ^ s3_dh_reg[DH_W-1];
        push_item.neg_y = s3_vneg_reg ^ s3_dh_reg[DH_W-1];
        push_item.neg_z = s3_dh_reg[DH_W-1];
        push_item.zero  = dzero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_ch.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dh_reg    <= dh_next;
            s1_u_reg     <= u_next;
            s1_vc_reg    <= v_next;
            s2_dh_reg    <= s1_dh_reg;
            s2_xt_reg    <= xt_next;
            s2_yp_reg    <= yp_next;
            s2_vneg_reg  <= s1_vc_reg[UV_W-1];
            s3_dh_reg    <= s2_dh_reg;
            s3_px_lo_reg <= px_lo_next;
            s3_px_hi_reg <= px_hi_next;
            s3_yp_reg    <= s2_yp_reg;
            s3_xneg_reg  <= s2_xt_reg[XT_W-1];
            s3_vneg_reg  <= s2_vneg_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stri_fifo.sv =====
// Short register queue of divide jobs between front and back ends.
// Uses stri_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module stri_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  stri_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output stri_pkg::item_t pop_item,
    output logic            not_empty
);
    import stri_pkg::*;

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_item  = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        FIFO_AW'(wr_reg - rd_reg) == cnt_reg[FIFO_AW-1:0])
        else $error("queue pointers disagree with count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

`default_nettype wire

// ===== rtl/core/stri_div.sv =====
// Pipelined unsigned restoring divider, DIV_STEPS quotient bits per stage.
// Uses stri_pkg for widths and stage count.
`timescale 1ns / 1ps
`default_nettype none

module stri_div (
    input  logic                   clk,
    input  logic                   adv,
    input  logic [stri_pkg::NUM_W-1:0] num_in,
    input  logic [stri_pkg::CTR_W-1:0] den_in,
    output logic [stri_pkg::NUM_W-1:0] quo
);
    import stri_pkg::*;

    // Numerator bits shift out the top while quotient bits shift in below.
    logic [NUM_W-1:0] nq_reg  [DIV_STAGES];
    logic [CTR_W-1:0] rem_reg [DIV_STAGES];
    logic [CTR_W-1:0] den_reg [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            logic [NUM_W-1:0] nq_src, nq_w;
            logic [CTR_W-1:0] rem_src, rem_w, den_src;
            logic [CTR_W:0]   trial;
            logic             ge;

            if (s == 0)
            begin : g_first
                assign nq_src  = num_in;
                assign rem_src = '0;
                assign den_src = den_in;
            end
            else
            begin : g_next
                assign nq_src  = nq_reg[s-1];
                assign rem_src = rem_reg[s-1];
                assign den_src = den_reg[s-1];
            end

            always_comb
            begin
                nq_w  = nq_src;
                rem_w = rem_src;
                trial = '0;
                ge    = 1'b0;
                for (int k = 0; k < DIV_STEPS; k++)
                begin
                    if (s * DIV_STEPS + k < NUM_W)
                    begin
                        trial = {rem_w, nq_w[NUM_W-1]};
                        ge    = (trial >= {1'b0, den_src});
                        nq_w  = {nq_w[NUM_W-2:0], ge};
                        rem_w = ge ? CTR_W'(trial - {1'b0, den_src}) : CTR_W'(trial);
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    nq_reg[s]  <= nq_w;
                    rem_reg[s] <= rem_w;
                    den_reg[s] <= den_src;
                end
            end
        end
    endgenerate

    assign quo = nq_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/stri_back.sv =====
// Back end: three pipelined dividers, camera saturation, rigid transform,
// truncation and output register. Uses stri_pkg, stri_if and stri_div.
`timescale 1ns / 1ps
`default_nettype none

module stri_back (
    input  logic            clk,
    input  logic            rst_n,
    input  stri_pkg::cfg_t  cfg,
    input  logic            fifo_valid,
    input  stri_pkg::item_t fifo_item,
    output logic            pop,
    stri_out_if.source      out_ch
);
    import stri_pkg::*;

    function automatic logic signed [CAM_W-1:0] sat_cam(input logic [NUM_W-1:0] q,
                                                        input logic neg);
        logic [CAM_W-1:0] mag;
        mag = (q > CAM_MAX) ? CAM_W'(CAM_MAX) : CAM_W'(q);
        sat_cam = neg ? -$signed(mag) : $signed(mag);
    endfunction

    logic adv;
    logic [NUM_W-1:0] qx, qy, qz;

    logic sbv_reg [DIV_STAGES];
    sb_t  sb_reg  [DIV_STAGES];

    logic cam_v_reg, prod_v_reg, acc_v_reg, out_v_reg;
    logic cam_z_reg, prod_z_reg, acc_z_reg, out_z_reg;

    logic signed [CAM_W-1:0]          cam_reg [3];
    logic [ROW_W-1:0]                 rows    [3];
    logic signed [ROT_W+CAM_LO_W:0]   plo_next [3][3];
    logic signed [ROT_W+CAM_HI_W-1:0] phi_next [3][3];
    logic signed [ROT_W+CAM_LO_W:0]   plo_reg  [3][3];
    logic signed [ROT_W+CAM_HI_W-1:0] phi_reg  [3][3];
    logic signed [ACC_W-1:0]          acc_next [3];
    logic signed [ACC_W-1:0]          acc_reg  [3];
    logic signed [ACC_W-1:0]          mm       [3];
    logic signed [COORD_BITS-1:0]     res_next [3];
    logic signed [COORD_BITS-1:0]     out_reg  [3];

    // Advance everything together unless the output word is stalled.
    assign adv = !out_v_reg || out_ch.ready;
    assign pop = adv && fifo_valid;

    stri_div u_div_x (.clk(clk), .adv(adv), .num_in(fifo_item.nx),
                      .den_in(fifo_item.den), .quo(qx));
    stri_div u_div_y (.clk(clk), .adv(adv), .num_in(fifo_item.ny),
                      .den_in(fifo_item.den), .quo(qy));
    stri_div u_div_z (.clk(clk), .adv(adv), .num_in(fifo_item.nz),
                      .den_in(fifo_item.den), .quo(qz));

    always_comb
    begin
        rows[0] = cfg.row_x;
        rows[1] = cfg.row_y;
        rows[2] = cfg.row_z;
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                plo_next[k][j] = $signed(rows[k][ROW_W-1-ROT_W*j -: ROT_W])
                               * $signed({1'b0, cam_reg[j][CAM_LO_W-1:0]});
                phi_next[k][j] = $signed(rows[k][ROW_W-1-ROT_W*j -: ROT_W])
                               * $signed(cam_reg[j][CAM_W-1:CAM_LO_W]);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc_next[k] = ACC_W'($signed(rows[k][ROT_W-1:0])) <<< OUT_FRAC;
            for (int j = 0; j < 3; j++)
                acc_next[k] = acc_next[k] + (ACC_W'(phi_reg[k][j]) <<< CAM_LO_W)
                            + ACC_W'(plo_reg[k][j]);
        end
    end

    // Truncate toward zero, then saturate to the output range; a zero-disparity word gives zero.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mm[k] = (acc_reg[k][ACC_W-1] ? acc_reg[k] + ACC_W'(ROUND_ADD) : acc_reg[k])
                    >>> OUT_FRAC;
            if (acc_z_reg)
                res_next[k] = '0;
            else if (mm[k] > ACC_W'(COORD_MAX))
                res_next[k] = COORD_BITS'(COORD_MAX);
            else if (mm[k] < ACC_W'(COORD_MIN))
                res_next[k] = COORD_BITS'(COORD_MIN);
            else
                res_next[k] = COORD_BITS'(mm[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                sbv_reg[i] <= 1'b0;
            cam_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
            acc_v_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else if (adv)
        begin
            sbv_reg[0] <= fifo_valid;
            for (int i = 1; i < DIV_STAGES; i++)
                sbv_reg[i] <= sbv_reg[i-1];
            cam_v_reg  <= sbv_reg[DIV_STAGES-1];
            prod_v_reg <= cam_v_reg;
            acc_v_reg  <= prod_v_reg;
            out_v_reg  <= acc_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[0] <= '{zero: fifo_item.zero, neg_x: fifo_item.neg_x,
                           neg_y: fifo_item.neg_y, neg_z: fifo_item.neg_z};
            for (int i = 1; i < DIV_STAGES; i++)
                sb_reg[i] <= sb_reg[i-1];
            cam_reg[0] <= sat_cam(qx, sb_reg[DIV_STAGES-1].neg_x);
            cam_reg[1] <= sat_cam(qy, sb_reg[DIV_STAGES-1].neg_y);
            cam_reg[2] <= sat_cam(qz, sb_reg[DIV_STAGES-1].neg_z);
            cam_z_reg  <= sb_reg[DIV_STAGES-1].zero;
            plo_reg    <= plo_next;
            phi_reg    <= phi_next;
            prod_z_reg <= cam_z_reg;
            acc_reg    <= acc_next;
            acc_z_reg  <= prod_z_reg;
            out_reg    <= res_next;
            out_z_reg  <= acc_z_reg;
        end
    end

    assign out_ch.valid          = out_v_reg;
    assign out_ch.base_x         = out_reg[0];
    assign out_ch.base_y         = out_reg[1];
    assign out_ch.base_z         = out_reg[2];
    assign out_ch.zero_disparity = out_z_reg;

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_z_reg) |-> (out_reg[0] == '0 && out_reg[1] == '0
                                      && out_reg[2] == '0))
        else $error("zero disparity word carries coordinates");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ch.ready) |=> (out_v_reg && $stable(out_z_reg)))
        else $error("stalled output word changed");

    a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ch.ready) |-> !pop)
        else $error("job taken while back end stalled");

endmodule

`default_nettype wire
